// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HMNM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HMNM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hmnm_pkg.sv -----
package hmnm_pkg;

  // default store geometry
  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;

  // commands
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_ALPHA  = 2'd2;
  localparam int CFG_DATA_W = 9;

  // arithmetic constants (slope 3, full scale 255, encode with 127 around 128)
  localparam int FLAT_SQ = 65025;          // 255 * 255
  localparam int X_SCALE = 97536;          // 381 * 256
  localparam int Z_NUM   = 8290560;        // 32385 * 256
  localparam logic [7:0] CENTER = 8'd128;

  // shared compare-subtract unit: radicand is below 2^37
  localparam int REM_W = 38;
  localparam logic [REM_W-1:0] ROOT_BIT0 = REM_W'(1) << 36;
  localparam int SQRT_STEPS = 19;
  localparam int DIV_STEPS  = 8;
  localparam int CNT_W = 5;
  localparam logic [REM_W-1:0] R_MIN = REM_W'(65280);

endpackage

// ----- rtl/height_map_to_normal_map_core.sv -----
// Height map to normal map core. A write transfer (command 0) stores one 8-bit
// height at (row, col) and returns nothing; writes outside image_width x
// image_rows are dropped. A compute transfer (command 1) returns one result
// after three reads of the single-port height store (centre, right and lower
// neighbour, wrapping at the configured size), two squarings, then a 19-step
// integer square root and three 8-step quotients, all on one shared
// compare-subtract unit, which sets the latency. in_stall is high for the
// whole computation. An out-of-range compute skips the store and returns zero
// data with out_of_range set. The output register lets the next transfer be
// taken while a result still waits. The store has no reset; reading a location
// that was never written gives an undefined normal. Configuration is to be
// written by the user only while the core is idle; the core does not enforce it.
`include "assert_macros.svh"

module height_map_to_normal_map_core #(
  parameter int MAX_COLS = hmnm_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = hmnm_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,

  input  logic                           cfg_write,
  input  logic [hmnm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hmnm_pkg::CFG_DATA_W-1:0] cfg_data,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic [7:0]                     row,
  input  logic [7:0]                     col,
  input  logic [7:0]                     height_value,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     normal_x,
  output logic [7:0]                     normal_y,
  output logic [7:0]                     normal_z,
  output logic [7:0]                     alpha_height,
  output logic                           out_of_range
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int REM_W  = hmnm_pkg::REM_W;
  localparam int CNT_W  = hmnm_pkg::CNT_W;
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(hmnm_pkg::SQRT_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(hmnm_pkg::DIV_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_DIFF, S_SQX, S_SQY, S_NORM,
    S_SQRT, S_DLOAD, S_DIV, S_DEND, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [8:0] image_width;
  logic [8:0] image_rows;
  logic       emit_alpha;

  // item registers
  logic [ADDR_W-1:0] addr_c, addr_r, addr_b;
  logic              oor;
  logic [7:0]        h, hr;
  logic signed [8:0] hx, hy;
  logic [16:0]       acc;
  logic [REM_W-1:0]  rem, res, bitv, dsh;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        div_sel;
  logic [7:0]        q;
  logic              neg;
  logic [7:0]        nx, ny, nz;

  // store
  logic [7:0]        mem [DEPTH];
  logic [7:0]        mem_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;

  // combinational helpers
  logic [8:0]        eff_w, eff_r;
  logic              in_image;
  logic              in_xfer;
  logic [8:0]        col_inc, row_inc;
  logic [8:0]        col_nb, row_nb;
  logic signed [8:0] mul_in;
  logic signed [17:0] mul_out;
  logic [20:0]       norm_n;
  logic [7:0]        abs_hx, abs_hy;
  logic [24:0]       scaled;
  logic [REM_W-1:0]  unit_b, unit_diff;
  logic              unit_ge;
  logic [7:0]        q_next;
  logic [7:0]        enc;

  always_comb begin
    if (image_width == '0) begin
      eff_w = 9'd1;
    end else if (32'(image_width) > MAX_COLS) begin
      eff_w = 9'(MAX_COLS);
    end else begin
      eff_w = image_width;
    end
    if (image_rows == '0) begin
      eff_r = 9'd1;
    end else if (32'(image_rows) > MAX_ROWS) begin
      eff_r = 9'(MAX_ROWS);
    end else begin
      eff_r = image_rows;
    end
  end

  assign in_image = ({1'b0, row} < eff_r) && ({1'b0, col} < eff_w);
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // neighbour coordinates wrap at the configured size
  assign col_inc = {1'b0, col} + 9'd1;
  assign row_inc = {1'b0, row} + 9'd1;
  assign col_nb  = (col_inc == eff_w) ? 9'd0 : col_inc;
  assign row_nb  = (row_inc == eff_r) ? 9'd0 : row_inc;

  assign mem_we  = in_xfer && (command == hmnm_pkg::CMD_WRITE) && in_image;
  assign wr_addr = ADDR_W'(32'(row) * MAX_COLS + 32'(col));

  always_comb begin
    unique case (state)
      S_RD1:   rd_addr = addr_r;
      S_RD2:   rd_addr = addr_b;
      default: rd_addr = addr_c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= height_value;
    end
    mem_q <= mem[rd_addr];
  end

  // one squarer, used for hx then hy
  assign mul_in  = (state == S_SQX) ? hx : hy;
  assign mul_out = mul_in * mul_in;
  assign norm_n  = ({4'b0, acc} << 3) + {4'b0, acc} + 21'(hmnm_pkg::FLAT_SQ);

  assign abs_hx = hx[8] ? 8'(-hx) : hx[7:0];
  assign abs_hy = hy[8] ? 8'(-hy) : hy[7:0];
  assign scaled = 25'(hmnm_pkg::X_SCALE) * 25'((div_sel == 2'd0) ? abs_hy : abs_hx);

  // shared compare-subtract unit: root trial value or shifted divisor
  assign unit_b    = (state == S_SQRT) ? res + bitv : dsh;
  assign unit_ge   = (rem >= unit_b);
  assign unit_diff = rem - unit_b;

  // floor toward minus infinity on negative quotients
  assign q_next = q;
  assign enc    = neg ? hmnm_pkg::CENTER - q_next - {7'b0, |rem}
                      : hmnm_pkg::CENTER + q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      image_width <= 9'd256;
      image_rows  <= 9'd256;
      emit_alpha  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          hmnm_pkg::REG_IMAGE_WIDTH: image_width <= cfg_data;
          hmnm_pkg::REG_IMAGE_ROWS:  image_rows  <= cfg_data;
          hmnm_pkg::REG_EMIT_ALPHA:  emit_alpha  <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer && (command == hmnm_pkg::CMD_COMPUTE)) begin
            addr_c <= wr_addr;
            addr_r <= ADDR_W'(32'(row) * MAX_COLS + 32'(col_nb));
            addr_b <= ADDR_W'(32'(row_nb) * MAX_COLS + 32'(col));
            oor    <= !in_image;
            state  <= in_image ? S_RD0 : S_OUT;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          h     <= mem_q;
          state <= S_RD2;
        end
        S_RD2: begin
          hr    <= mem_q;
          state <= S_DIFF;
        end
        S_DIFF: begin
          hx    <= $signed({1'b0, h}) - $signed({1'b0, hr});
          hy    <= $signed({1'b0, h}) - $signed({1'b0, mem_q});
          state <= S_SQX;
        end
        S_SQX: begin
          acc   <= 17'(mul_out);
          state <= S_SQY;
        end
        S_SQY: begin
          acc   <= acc + 17'(mul_out);
          state <= S_NORM;
        end
        S_NORM: begin
          rem   <= REM_W'({norm_n, 16'b0});
          res   <= '0;
          bitv  <= hmnm_pkg::ROOT_BIT0;
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (unit_ge) begin
            rem <= unit_diff;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt + CNT_W'(1);
          if (cnt == SQRT_LAST) begin
            div_sel <= 2'd0;
            state   <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          dsh <= res << (hmnm_pkg::DIV_STEPS - 1);
          q   <= '0;
          cnt <= '0;
          unique case (div_sel)
            2'd0: begin
              rem <= REM_W'(scaled);
              neg <= hy[8];
            end
            2'd1: begin
              rem <= REM_W'(scaled);
              neg <= !hx[8] && (hx != '0);
            end
            default: begin
              rem <= REM_W'(hmnm_pkg::Z_NUM);
              neg <= 1'b0;
            end
          endcase
          state <= S_DIV;
        end
        S_DIV: begin
          if (unit_ge) begin
            rem <= unit_diff;
          end
          q   <= {q[6:0], unit_ge};
          dsh <= dsh >> 1;
          cnt <= cnt + CNT_W'(1);
          if (cnt == DIV_LAST) begin
            state <= S_DEND;
          end
        end
        S_DEND: begin
          unique case (div_sel)
            2'd0:    nx <= enc;
            2'd1:    ny <= enc;
            default: nz <= enc;
          endcase
          if (div_sel == 2'd2) begin
            state <= S_OUT;
          end else begin
            div_sel <= div_sel + 2'd1;
            state   <= S_DLOAD;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            out_of_range <= oor;
            normal_x     <= oor ? 8'd0 : nx;
            normal_y     <= oor ? 8'd0 : ny;
            normal_z     <= oor ? 8'd0 : nz;
            alpha_height <= (oor || !emit_alpha) ? 8'd0 : h;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `HMNM_ASSERT_IMPL(a_oor_zero, out_valid && out_of_range, (normal_x == 8'd0) && (normal_y == 8'd0) && (normal_z == 8'd0) && (alpha_height == 8'd0), "out of range result carries data")
  `HMNM_ASSERT_IMPL(a_z_upper, out_valid && !out_of_range, normal_z[7], "normal z below center")
  `HMNM_ASSERT_NEXT(a_root_min, (state == S_SQRT) && (cnt == SQRT_LAST), res >= hmnm_pkg::R_MIN, "root below flat length")
  `HMNM_ASSERT_NEXT(a_write_silent, in_xfer && (command == hmnm_pkg::CMD_WRITE) && !out_valid, !out_valid, "write produced a result")

endmodule
